// ===== src/bounded_deque_with_remove_match_unit_defines.svh =====
// Assertion macros for the bounded deque unit.
// Used by the top level only; no other dependencies.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MATCH_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MATCH_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BDQ_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdq assertion failed");

// Check that a condition implies another in the next cycle.
`define BDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdq assertion failed");

`endif

// ===== src/bdq_pkg.sv =====
// Shared types, widths, codes and address helper for the bounded deque unit.
// No dependencies; every other file but the defines header imports this package.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    // Memory port request from the sequencer
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        data_t wdata;
        idx_t  raddr;
    } mem_req_t;

    // Map a logical position (0 = front) to a storage slot
    function automatic idx_t slot_of(input idx_t front, input cnt_t k);
        sum_t sum;
        sum = SUM_W'(front) + SUM_W'(k);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/bdq_cmd_if.sv =====
// Request channel of the bounded deque unit: operation and value.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_cmd_if import bdq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ===== src/bdq_rsp_if.sv =====
// Result channel of the bounded deque unit: popped word, status, occupancy.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_rsp_if import bdq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] popped;
    logic [1:0]        status;
    logic [CNT_W-1:0]  occupancy;

    modport source (output valid, output popped, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ===== src/bdq_mem.sv =====
// Entry store of the bounded deque: one write port, one registered read port.
// Depends on bdq_pkg.
`default_nettype none

module bdq_mem import bdq_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output data_t         rd_data
);

    data_t mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== src/bdq_seq.sv =====
// Sequencer of the bounded deque: decodes a request, walks the store for
// remove, compacts it, and holds the result register. Depends on bdq_pkg,
// bdq_cmd_if and bdq_rsp_if.
`default_nettype none

module bdq_seq import bdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp,
    output mem_req_t  mem_req,
    input  wire data_t rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    data_t           val_reg, val_next;
    idx_t            front_reg, front_next;
    cnt_t            count_reg, count_next;
    cnt_t            k_reg, k_next;
    data_t           res_popped_reg, res_popped_next;
    status_t         res_status_reg, res_status_next;
    logic            out_valid_reg, out_valid_next;
    data_t           out_popped_reg, out_popped_next;
    status_t         out_status_reg, out_status_next;
    cnt_t            out_occ_reg, out_occ_next;

    cnt_t            rd_k;
    sum_t            kp1, kp2;
    idx_t            front_dec, front_inc;

    assign kp1 = SUM_W'(k_reg) + SUM_W'(1);
    assign kp2 = SUM_W'(k_reg) + SUM_W'(2);

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    assign cmd.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.popped    = out_popped_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.occupancy = out_occ_reg;

    // Next-state and memory request logic
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        res_popped_next = res_popped_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        rd_k            = '0;
        mem_req.we      = 1'b0;
        mem_req.waddr   = slot_of(front_reg, k_reg);
        mem_req.wdata   = val_reg;

        // Drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    val_next   = cmd.value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_popped_next = '0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                case (op_reg)
                    OP_PUSH_BACK:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = slot_of(front_reg, count_reg);
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    OP_PUSH_FRONT:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = front_dec;
                            front_next    = front_dec;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_k       = '0;
                            front_next = front_inc;
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_k       = count_reg - CNT_W'(1);
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        res_status_next = ST_NOMATCH;
                        if (val_reg != '0 && count_reg != '0)
                        begin
                            rd_k       = '0;
                            k_next     = '0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        front_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                res_popped_next = rd_data;
                state_next      = S_DONE;
            end

            // Compare one entry per cycle, fetching the next one meanwhile
            S_SCAN:
            begin
                if (rd_data == val_reg)
                begin
                    if (kp1 < SUM_W'(count_reg))
                    begin
                        rd_k       = kp1[CNT_W-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next      = count_reg - CNT_W'(1);
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                end
                else if (kp1 < SUM_W'(count_reg))
                begin
                    rd_k   = kp1[CNT_W-1:0];
                    k_next = kp1[CNT_W-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Move entry k+1 down to k, fetching k+2 meanwhile
            S_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_of(front_reg, k_reg);
                mem_req.wdata = rd_data;
                if (kp2 < SUM_W'(count_reg))
                begin
                    rd_k   = kp2[CNT_W-1:0];
                    k_next = kp1[CNT_W-1:0];
                end
                else
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = res_popped_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mem_req.raddr = slot_of(front_reg, rd_k);
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            val_reg        <= '0;
            front_reg      <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            res_popped_reg <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_popped_reg <= '0;
            out_status_reg <= ST_OK;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            res_popped_reg <= res_popped_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_popped_reg <= out_popped_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bounded_deque_with_remove_match_unit.sv =====
// Bounded deque of DEPTH words with push/pop at both ends, order-keeping
// remove of the first matching word, and clear. One request gives one result.
// A request is taken only while the sequencer is idle. Pushes, clear and
// undefined codes go from the execute state to the done state; pops pass
// a wait state between them for the registered read of the store. Remove of
// a nonzero value from a nonempty deque compares the entries in turn up to
// the match or the end, then moves each entry behind it down by one place,
// through the one read and one write port that the scan and compaction share.
// The result sits in an output register, so the next request is taken while
// it waits; the request after that stalls until the register is free.
// Depends on bdq_pkg, bdq_cmd_if, bdq_rsp_if, bdq_mem, bdq_seq.
`default_nettype none

`include "bounded_deque_with_remove_match_unit_defines.svh"

module bounded_deque_with_remove_match_unit import bdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp
);

    mem_req_t mem_req;
    data_t    rd_data;

    // Sequence each request
    bdq_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Hold the entries
    bdq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    `BDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready)
    `BDQ_ASSERT_SAME(a_occ_bound, clk, rst_n, rsp.valid, rsp.occupancy <= CNT_W'(DEPTH))
    `BDQ_ASSERT_SAME(a_full_occ, clk, rst_n, rsp.valid && rsp.status == ST_FULL, rsp.occupancy == CNT_W'(DEPTH))
    `BDQ_ASSERT_SAME(a_empty_pop, clk, rst_n, rsp.valid && rsp.status == ST_EMPTY, rsp.occupancy == '0 && rsp.popped == '0)

endmodule

`default_nettype wire
